FILE: hw/rtl/base64_stream_encoder_assert.svh
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// concurrent checks, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define B64_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");
// next-cycle implication
`define B64_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define B64_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define B64_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/b64se_pkg.sv
// ----------------------------------------------------------------------------
// b64se_pkg
// shared types, constants and the alphabet lookup of the base64 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64se_pkg;

	// group queue geometry
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// pad character
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// position within the 3-byte group
	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2
	} group_pos_t;

	// one closed group handed from front to back
	typedef struct packed {
		logic [23:0] bits;     // first byte in 23:16
		logic [1:0]  n_bytes;  // 1..3 input bytes in the group
		logic        last;     // group closes the message
	} group_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// sextet to ascii, standard alphabet
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		priority if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64se_if.sv
// ----------------------------------------------------------------------------
// b64se channel interfaces
// valid/ready channels for raw bytes in and encoded characters out
// ----------------------------------------------------------------------------
`default_nettype none

interface b64se_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64se_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       end_of_text;

	modport source (output valid, output out_char, output end_of_text, input ready);
	modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
//  channel  dir  payload                  accept
//  bytes    in   data_byte, final_byte    valid && ready
//  chars    out  out_char, end_of_text    valid && ready
//
//  bytes are taken one per cycle while the two-entry group queue has room
//  each closed group leaves as four characters, one per cycle while
//  chars.ready is high, from the back serializer, which takes the next
//  queued group as it sends the last character of the current one
//  reset clears the group position, queue pointers and serializer at once
//  a stalled chars side fills the queue, then drops bytes.ready
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder (
	input  wire           clk,
	input  wire           arst_n,
	b64se_byte_if.sink    bytes,
	b64se_char_if.source  chars
);

	b64se_pkg::queue_status_t q_status;
	b64se_pkg::group_t        push_group;
	b64se_pkg::group_t        pop_group;
	logic                     push;
	logic                     pop;

	// byte gathering
	b64se_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.q_status   (q_status),
		.push       (push),
		.push_group (push_group)
	);

	// group queue
	b64se_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.pop_group  (pop_group),
		.status     (q_status)
	);

	// character serializer
	b64se_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_group (pop_group),
		.pop       (pop),
		.chars     (chars)
	);

	// no push into a full queue
	`B64_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !q_status.full)
	// every pushed group holds one to three bytes
	`B64_ASSERT_IMPLIES(a_group_size, clk, arst_n, push, push_group.n_bytes != 2'd0)
	// the output goes idle after the message end when nothing is queued
	`B64_ASSERT_NEXT(a_idle_after_end, clk, arst_n,
		chars.valid && chars.ready && chars.end_of_text && q_status.empty, !chars.valid)

endmodule

`default_nettype wire

FILE: hw/rtl/b64se_front.sv
// ----------------------------------------------------------------------------
// b64se_front
// gathers bytes into 3-byte groups and pushes closed groups to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_front (
	input  wire                    clk,
	input  wire                    arst_n,
	b64se_byte_if.sink             bytes,
	input  b64se_pkg::queue_status_t q_status,
	output logic                   push,
	output b64se_pkg::group_t      push_group
);

	b64se_pkg::group_pos_t pos_q;
	logic [15:0]           held_q;
	logic                  accept;
	logic                  closes;

	// take a word whenever the queue has room
	assign bytes.ready = !q_status.full;
	assign accept      = bytes.valid && bytes.ready;

	// group closes on the third byte or on the final byte
	assign closes = bytes.final_byte || (pos_q == b64se_pkg::POS_THIRD);
	assign push   = accept && closes;

	// assemble the closed group
	always_comb begin
		push_group.last = bytes.final_byte;
		unique case (pos_q)
			b64se_pkg::POS_SECOND: begin
				push_group.bits    = {held_q[15:8], bytes.data_byte, 8'h00};
				push_group.n_bytes = 2'd2;
			end
			b64se_pkg::POS_THIRD: begin
				push_group.bits    = {held_q, bytes.data_byte};
				push_group.n_bytes = 2'd3;
			end
			default: begin
				push_group.bits    = {bytes.data_byte, 16'h0000};
				push_group.n_bytes = 2'd1;
			end
		endcase
	end

	// position and held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= b64se_pkg::POS_FIRST;
			held_q <= 16'h0000;
		end else if (accept) begin
			if (closes) begin
				pos_q  <= b64se_pkg::POS_FIRST;
				held_q <= 16'h0000;
			end else if (pos_q == b64se_pkg::POS_SECOND) begin
				pos_q  <= b64se_pkg::POS_THIRD;
				held_q <= {held_q[15:8], bytes.data_byte};
			end else begin
				pos_q  <= b64se_pkg::POS_SECOND;
				held_q <= {bytes.data_byte, 8'h00};
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/b64se_queue.sv
// ----------------------------------------------------------------------------
// b64se_queue
// short fifo of closed groups between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  b64se_pkg::group_t        push_group,
	input  wire                      pop,
	output b64se_pkg::group_t        pop_group,
	output b64se_pkg::queue_status_t status
);

	b64se_pkg::group_t                  entry_q [b64se_pkg::QUEUE_DEPTH];
	logic [b64se_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [b64se_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [b64se_pkg::QCNT_W-1:0]       count_q;
	logic                               do_push;
	logic                               do_pop;

	assign status.full  = (count_q == b64se_pkg::QCNT_W'(b64se_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_group    = entry_q[rd_ptr_q];

	// pointer wrap
	function automatic logic [b64se_pkg::QPTR_W-1:0] next_ptr(
		input logic [b64se_pkg::QPTR_W-1:0] p
	);
		logic [b64se_pkg::QPTR_W-1:0] n;
		if (p == b64se_pkg::QPTR_W'(b64se_pkg::QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_group;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/b64se_back.sv
// ----------------------------------------------------------------------------
// b64se_back
// serializes one group into four characters, one word per cycle while chars.ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  b64se_pkg::queue_status_t q_status,
	input  b64se_pkg::group_t        pop_group,
	output logic                     pop,
	b64se_char_if.source             chars
);

	b64se_pkg::group_t grp_q;
	logic              busy_q;
	logic [1:0]        idx_q;
	logic              fire;
	logic              group_done;
	logic [5:0]        sextet;

	assign fire       = chars.valid && chars.ready;
	assign group_done = fire && (idx_q == 2'd3);
	assign pop        = !q_status.empty && (!busy_q || group_done);

	// sextet of the current character, most significant first
	always_comb begin
		unique case (idx_q)
			2'd0:    sextet = grp_q.bits[23:18];
			2'd1:    sextet = grp_q.bits[17:12];
			2'd2:    sextet = grp_q.bits[11:6];
			default: sextet = grp_q.bits[5:0];
		endcase
	end

	// output word from the held group
	assign chars.valid       = busy_q;
	assign chars.out_char    = (idx_q <= grp_q.n_bytes) ? b64se_pkg::sextet_char(sextet)
	                                                   : b64se_pkg::PAD_CHAR;
	assign chars.end_of_text = grp_q.last && (idx_q == 2'd3);

	// group register
	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= pop_group;
		end
	end

	// character counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (group_done) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire
